>>> rtl/kwm_pkg.sv
package kwm_pkg;

  // Field widths of the request and result channels
  localparam int KEY_W = 32;
  localparam int WAY_W = 3;
  localparam int CFG_W = 4;

  // Active-ways register value after reset
  localparam logic [CFG_W-1:0] ACTIVE_WAYS_RST = 4'd8;

  // Request opcodes
  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_DONE = 1'b1
  } opcode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Running minimum that travels down the cell chain
  typedef struct packed {
    logic             live;
    logic             any;
    logic             ready;
    logic [KEY_W-1:0] key;
  } scan_t;

endpackage

>>> rtl/kwm_in_if.sv
interface kwm_in_if;
  import kwm_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [WAY_W-1:0] way;
  logic [KEY_W-1:0] key;

  modport source (output valid, output opcode, output way, output key, input ready);
  modport sink   (input valid, input opcode, input way, input key, output ready);
endinterface

>>> rtl/kwm_out_if.sv
interface kwm_out_if;
  import kwm_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [WAY_W-1:0] source_way;

  modport source (output valid, output out_key, output source_way, input ready);
  modport sink   (input valid, input out_key, input source_way, output ready);
endinterface

>>> rtl/k_way_merge_select_core.sv
// K-way merge selector. One request either loads the next key of a way or
// closes that way; after each request the block looks for the smallest
// valid head over the active ways and, when every active way holds a head
// or is closed and at least one head is present, returns that key with its
// way and frees the head (lowest way wins ties). Each request is applied, then
// the running minimum passes one cell per cycle down the row of way cells, is
// caught in a register at the end of the row, and the result is picked. The
// result sits in an output register, so the next request is taken while it
// waits; a new result stalls only when the previous one is still not taken.
// cfg_data sets the active way count (0 acts as 1, above WAYS acts as WAYS)
// and may be written only while no request is in flight.
module k_way_merge_select_core import kwm_pkg::*; #(
  parameter int WAYS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  kwm_in_if.sink           in_ch,
  kwm_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(WAYS);
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SEL_W = ((IDX_W > WAY_W) ? IDX_W : WAY_W) + 1;

  logic [CFG_W-1:0] active_ways_r;
  logic [CMP_W-1:0] n_eff;
  state_t           state_r;
  state_t           state_nxt;
  logic             in_ready;
  logic             accept;
  logic             start_r;
  logic             emit_go;
  scan_t            pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [WAY_W-1:0] out_way_r;
  logic [WAYS-1:0]  cell_act;
  logic [WAYS:0]    tok_vec;
  scan_t            chain [WAYS+1];
  logic [IDX_W-1:0] chain_idx [WAYS+1];

  assign accept = in_ch.valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ways_r <= ACTIVE_WAYS_RST;
    end else if (cfg_we) begin
      active_ways_r <= cfg_data;
    end
  end

  // Clamp the way count into 1..WAYS
  always_comb begin
    priority if (active_ways_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(active_ways_r) > CMP_W'(WAYS)) begin
      n_eff = CMP_W'(WAYS);
    end else begin
      n_eff = CMP_W'(active_ways_r);
    end
  end

  // Chain head: a fresh token starts in the cycle after the request is applied
  assign chain[0]     = '{live: start_r, any: 1'b0, ready: 1'b1, key: '0};
  assign chain_idx[0] = '0;
  assign tok_vec[0]   = start_r;

  // Row of way cells
  for (genvar g = 0; g < WAYS; g++) begin : g_cell
    logic hit;
    logic clr;

    assign cell_act[g] = CMP_W'(g) < n_eff;
    assign hit = accept && cell_act[g] && (SEL_W'(in_ch.way) == SEL_W'(g));
    assign clr = emit_go && (pend_idx_r == IDX_W'(g));
    assign tok_vec[g+1] = chain[g+1].live;

    kwm_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .active    (cell_act[g]),
      .wr_en     (hit),
      .wr_op     (in_ch.opcode),
      .wr_key    (in_ch.key),
      .clr       (clr),
      .carry_in  (chain[g]),
      .idx_in    (chain_idx[g]),
      .carry_out (chain[g+1]),
      .idx_out   (chain_idx[g+1])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    emit_go   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[WAYS].live) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!(pend_r.any && pend_r.ready)) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          emit_go   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Catch the finished minimum at the end of the row
  always_ff @(posedge clk) begin
    if (chain[WAYS].live) begin
      pend_r     <= chain[WAYS];
      pend_idx_r <= chain_idx[WAYS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_key_r <= pend_r.key;
      out_way_r <= WAY_W'(pend_idx_r);
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_key    = out_key_r;
  assign out_ch.source_way = out_way_r;

  // At most one scan token in the row at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  // No request is taken while a scan is in flight
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (tok_vec == '0))
    else $error("request taken during a scan");

  // A selected head lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && (out_key_r == $past(pend_r.key))))
    else $error("selected key not loaded into output register");

  // Selection happens only with a complete and nonempty set of heads
  a_emit_legal: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> ((state_r == ST_EMIT) && pend_r.any && pend_r.ready))
    else $error("result issued outside the select step");

endmodule

>>> rtl/kwm_cell.sv
module kwm_cell import kwm_pkg::*; #(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             active,
  input  logic             wr_en,
  input  logic             wr_op,
  input  logic [KEY_W-1:0] wr_key,
  input  logic             clr,
  input  scan_t            carry_in,
  input  logic [IDX_W-1:0] idx_in,
  output scan_t            carry_out,
  output logic [IDX_W-1:0] idx_out
);

  logic [KEY_W-1:0] key_r;
  logic             valid_r;
  logic             done_r;
  scan_t            carry_r;
  scan_t            carry_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             load_key;

  // New head is taken only when the slot is empty and the run is open
  assign load_key = wr_en && (wr_op == OP_KEY) && !done_r && !valid_r;

  // Head and flags of this way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
    end else if (wr_en) begin
      if (wr_op == OP_DONE) begin
        done_r <= 1'b1;
      end else if (load_key) begin
        valid_r <= 1'b1;
      end
    end else if (clr) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_key) begin
      key_r <= wr_key;
    end
  end

  // Fold this head into the running minimum; strict less keeps the lower way on ties
  always_comb begin
    carry_nxt = carry_in;
    idx_nxt   = idx_in;
    if (carry_in.live && active) begin
      if (valid_r) begin
        if (!carry_in.any || (key_r < carry_in.key)) begin
          carry_nxt.any = 1'b1;
          carry_nxt.key = key_r;
          idx_nxt       = IDX_W'(IDX);
        end
      end else if (!done_r) begin
        carry_nxt.ready = 1'b0;
      end
    end
  end

  // Hand-off register to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign carry_out = carry_r;
  assign idx_out   = idx_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kwm_pkg::*;

  localparam int WAYS       = 8;
  localparam int SETTLE     = 3 * (WAYS + 2);
  localparam int RAND_ITEMS = 1300;
  localparam int PHASES     = 10;

  // How a request's result is checked
  localparam logic [1:0] CHK_MODEL = 2'd0;
  localparam logic [1:0] CHK_NONE  = 2'd1;
  localparam logic [1:0] CHK_ONE   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [WAY_W-1:0] way;
  } merged_t;

  typedef struct packed {
    logic             is_cfg;
    opcode_t          op;
    logic [WAY_W-1:0] way;
    logic [KEY_W-1:0] key;
    logic [CFG_W-1:0] cfg;
    logic [1:0]       chk;
    merged_t          exp;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  kwm_in_if  in_bus ();
  kwm_out_if out_bus ();

  k_way_merge_select_core #(.WAYS(WAYS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // Mirror of the merge state
  logic [KEY_W-1:0] m_head_key   [WAYS];
  logic             m_head_valid [WAYS];
  logic             m_done       [WAYS];
  logic [CFG_W-1:0] m_active;

  merged_t merged_q [$];
  row_t    dir_tab  [$];
  int      errors     = 0;
  int      n_req      = 0;
  int      n_merged   = 0;
  int      n_cfg      = 0;
  int      burst_left = 0;

  logic [15:0] rdy_cnt  = '0;
  logic [1:0]  rdy_mode = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int eff_ways();
    if (m_active == 0) return 1;
    if (m_active > WAYS) return WAYS;
    return int'(m_active);
  endfunction

  // Apply one request to the mirror; returns 1 with the selected head when one is due
  function automatic bit merge_select(input opcode_t op, input logic [WAY_W-1:0] w,
                                      input logic [KEY_W-1:0] k, output merged_t res);
    int n;
    bit all_ready;
    bit any;
    int best;
    n = eff_ways();
    all_ready = 1'b1;
    any = 1'b0;
    best = 0;
    res = '0;
    if (int'(w) < n) begin
      if (op == OP_KEY) begin
        if (!m_done[w] && !m_head_valid[w]) begin
          m_head_key[w]   = k;
          m_head_valid[w] = 1'b1;
        end
      end else begin
        m_done[w] = 1'b1;
      end
    end
    // strict compare keeps the lowest way on ties
    for (int i = 0; i < n; i++) begin
      if (m_head_valid[i]) begin
        if (!any || m_head_key[i] < m_head_key[best]) begin
          best = i;
          any  = 1'b1;
        end
      end else if (!m_done[i]) begin
        all_ready = 1'b0;
      end
    end
    if (!all_ready || !any) return 1'b0;
    m_head_valid[best] = 1'b0;
    res.key = m_head_key[best];
    res.way = best[WAY_W-1:0];
    return 1'b1;
  endfunction

  // Extremes, small values for ties, and full-range keys
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 15));
      4: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t req_row(input opcode_t op, input logic [WAY_W-1:0] w,
                                   input logic [KEY_W-1:0] k, input logic [1:0] chk,
                                   input logic [KEY_W-1:0] ek = '0,
                                   input logic [WAY_W-1:0] ew = '0);
    row_t r;
    r = '0;
    r.op = op;
    r.way = w;
    r.key = k;
    r.chk = chk;
    r.exp.key = ek;
    r.exp.way = ew;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_W-1:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg = v;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // Issue one request, record its expectation on accept, then idle per the burst pattern
  task automatic send(input opcode_t op, input logic [WAY_W-1:0] w,
                      input logic [KEY_W-1:0] k, input logic [1:0] chk, input merged_t typed);
    merged_t res;
    bit      hit;
    int      gap;
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= op;
    in_bus.way    <= w;
    in_bus.key    <= k;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_req++;
    hit = merge_select(op, w, k, res);
    if (chk == CHK_ONE) begin
      merged_q.insert(merged_q.size(), typed);
    end else if (chk == CHK_MODEL && hit) begin
      merged_q.insert(merged_q.size(), res);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 14);
      burst_left = $urandom_range(0, 24);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off until every expected key is out and the last request has settled
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_ways(input logic [CFG_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    m_active = v;
    n_cfg++;
  endtask

  // Mostly keys for ways that lack a head, plus noise; every request counts
  task automatic random_phase(input int count);
    int               cands [$];
    int               n;
    int               pick;
    int               done_cnt;
    opcode_t          op;
    logic [WAY_W-1:0] w;
    done_cnt = 0;
    while (done_cnt < count) begin
      n = eff_ways();
      cands.delete();
      for (int i = 0; i < n; i++) begin
        if (!m_done[i] && !m_head_valid[i]) cands.insert(cands.size(), i);
      end
      if (cands.size() != 0 && $urandom_range(0, 99) < 85) begin
        pick = cands[$urandom_range(0, cands.size() - 1)];
        send(OP_KEY, pick[WAY_W-1:0], rand_key(), CHK_MODEL, '0);
      end else begin
        w  = WAY_W'($urandom_range(0, WAYS - 1));
        op = opcode_t'($urandom_range(0, 1));
        // closing a live way is permanent: ways 0-2 stay open, the rest close rarely
        if (op == OP_DONE && int'(w) < n && !m_done[w] &&
            (w < 3 || $urandom_range(0, 19) != 0)) begin
          op = OP_KEY;
        end
        send(op, w, rand_key(), CHK_MODEL, '0);
      end
      done_cnt++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : chk_out
    merged_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (merged_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result key=%h way=%0d", $time,
                 out_bus.out_key, out_bus.source_way);
      end else begin
        want = merged_q.pop_front();
        n_merged++;
        if (out_bus.out_key !== want.key || out_bus.source_way !== want.way) begin
          errors++;
          $display("%0t: mismatch expected key=%h way=%0d, got key=%h way=%0d", $time,
                   want.key, want.way, out_bus.out_key, out_bus.source_way);
        end
      end
    end
  end

  // Receiver stall pattern; a new mode is drawn each time the low byte of rdy_cnt wraps to zero
  always @(posedge clk) begin : out_stall
    rdy_cnt <= rdy_cnt + 1'b1;
    if (rdy_cnt[7:0] == 8'd0) rdy_mode <= 2'($urandom_range(0, 3));
    case (rdy_mode)
      2'd0: out_bus.ready <= 1'b1;
      2'd1: out_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_bus.ready <= (rdy_cnt[2:0] < 3'd5);
      default: out_bus.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  initial begin : stim
    logic [CFG_W-1:0] phase_cfg [PHASES];
    row_t             row;
    logic [WAY_W-1:0] w;
    int               open_cnt;

    in_bus.valid  = 1'b0;
    in_bus.opcode = OP_KEY;
    in_bus.way    = '0;
    in_bus.key    = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      m_head_key[i]   = '0;
      m_head_valid[i] = 1'b0;
      m_done[i]       = 1'b0;
    end
    m_active = ACTIVE_WAYS_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill all eight ways from reset, extreme keys, ties to the lowest way
    add_row(req_row(OP_KEY, 3'd0, 32'hFFFF_FFFF, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd1, 32'h0000_0000, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd2, 32'h8000_0000, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd3, 32'h7FFF_FFFF, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd4, 32'hFFFF_FFFF, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd5, 32'h0000_0001, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd6, 32'h0000_0000, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd7, 32'h1234_5678, CHK_ONE, 32'h0, 3'd1));
    add_row(req_row(OP_KEY, 3'd1, 32'h0000_0000, CHK_ONE, 32'h0, 3'd1));
    // redundant key while the head is held
    add_row(req_row(OP_KEY, 3'd0, 32'h0000_0005, CHK_NONE));
    // zero acts as one way; the request to an inactive way still lets way 0 go out
    add_row(cfg_row(4'd0));
    add_row(req_row(OP_KEY, 3'd3, 32'h0000_0007, CHK_ONE, 32'hFFFF_FFFF, 3'd0));
    add_row(req_row(OP_KEY, 3'd0, 32'hFFFF_FFFF, CHK_ONE, 32'hFFFF_FFFF, 3'd0));
    // above the way count acts as all ways; inactive heads come back
    add_row(cfg_row(4'd15));
    add_row(req_row(OP_KEY, 3'd0, 32'h0000_0002, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd1, 32'h0000_0003, CHK_ONE, 32'h0, 3'd6));
    // close an empty way, close it again, then a key after close
    add_row(req_row(OP_DONE, 3'd6, 32'h0, CHK_ONE, 32'h1, 3'd5));
    add_row(req_row(OP_DONE, 3'd6, 32'h0, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd6, 32'h0000_0009, CHK_NONE));
    // close a way that still holds a head
    add_row(req_row(OP_DONE, 3'd7, 32'h0, CHK_NONE));
    add_row(req_row(OP_KEY, 3'd5, 32'h1234_5678, CHK_ONE, 32'h2, 3'd0));
    add_row(req_row(OP_KEY, 3'd0, 32'h1234_5678, CHK_ONE, 32'h3, 3'd1));
    add_row(req_row(OP_KEY, 3'd1, 32'h1234_5678, CHK_ONE, 32'h1234_5678, 3'd0));
    add_row(cfg_row(4'd4));
    add_row(req_row(OP_KEY, 3'd5, 32'h0, CHK_MODEL));
    add_row(req_row(OP_KEY, 3'd0, 32'hFFFF_FFFF, CHK_MODEL));
    add_row(req_row(OP_KEY, 3'd2, 32'h0000_0005, CHK_MODEL));
    add_row(req_row(OP_KEY, 3'd1, 32'hFFFF_FFFF, CHK_MODEL));

    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      if (row.is_cfg) set_ways(row.cfg);
      else send(row.op, row.way, row.key, row.chk, row.exp);
    end

    // Random phases across way counts, extremes included
    phase_cfg = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd6, 4'd2, 4'd12, 4'd5, 4'd7};
    phase_cfg[7] = CFG_W'($urandom_range(0, 15));
    for (int p = 0; p < PHASES; p++) begin
      set_ways(phase_cfg[p]);
      random_phase(RAND_ITEMS / PHASES);
    end

    // Close every way, then flush held heads with ignored requests
    set_ways(4'd8);
    do begin
      w = WAY_W'($urandom_range(0, WAYS - 1));
      if (!m_done[w]) begin
        send(($urandom_range(0, 2) == 0 || m_head_valid[w]) ? OP_DONE : OP_KEY,
             w, rand_key(), CHK_MODEL, '0);
      end
      open_cnt = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (!m_done[i]) open_cnt++;
      end
    end while (open_cnt != 0);
    repeat (WAYS + 4) begin
      send(opcode_t'($urandom_range(0, 1)), 3'($urandom_range(0, WAYS - 1)),
           rand_key(), CHK_MODEL, '0);
    end

    drain();
    $display("Run covered %0d requests over %0d way-count settings, %0d merged keys checked.",
             n_req, n_cfg, n_merged);
    $display("All ways were closed at the end and the held heads drained; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
